/* design/fpba_pkg.sv */
// Shared types and constants for the fit-policy block allocator.
package fpba_pkg;

  localparam int SlotCount   = 128;
  localparam int MemoryBytes = 1024;
  localparam int IdxW        = $clog2(SlotCount);
  localparam int LenW        = 11;
  localparam int TagW        = 8;

  typedef logic [IdxW-1:0] idx_t;
  typedef logic [LenW-1:0] len_t;
  typedef logic [TagW-1:0] tag_t;

  typedef enum logic [1:0] {
    ACT_ALLOC   = 2'd0,
    ACT_REALLOC = 2'd1,
    ACT_FREE    = 2'd2,
    ACT_NONE    = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    POL_FIRST = 2'd0,
    POL_BEST  = 2'd1,
    POL_WORST = 2'd2,
    POL_OFF   = 2'd3
  } policy_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_FIT   = 2'd1,
    ST_NO_OWNER = 2'd2,
    ST_RSVD     = 2'd3
  } status_t;

  // Scan mode for the datapath's sweep over the table.
  typedef enum logic [1:0] {
    SCAN_FIT   = 2'd0,
    SCAN_OWNER = 2'd1,
    SCAN_EMPTY = 2'd2,
    SCAN_NEXT  = 2'd3
  } scan_t;

  // Table write operations applied by the datapath.
  typedef enum logic [2:0] {
    WR_NONE    = 3'd0,
    WR_PLACE   = 3'd1,
    WR_SPILL   = 3'd2,
    WR_RELEASE = 3'd3,
    WR_SHRINK  = 3'd4,
    WR_GROW    = 3'd5,
    WR_TAKE    = 3'd6
  } wr_op_t;

  typedef struct packed {
    logic    clear;
    logic    scan_start;
    scan_t   scan_mode;
    policy_t policy;
    len_t    req_len;
    idx_t    addr;
    wr_op_t  wr_op;
    len_t    wr_len;
    tag_t    wr_tag;
  } dp_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic found;
    idx_t hit_idx;
    len_t hit_len;
    logic rd_busy;
    len_t rd_len;
    logic clear_done;
  } dp_stat_t;

endpackage

/* design/fit_policy_block_allocator_top.sv */
// Top level of the fit-policy block allocator.
//   channel | dir | fields
//   in_     | in  | tdata: action[1:0], owner_tag[9:2], request_size[20:10]
//   out_    | out | tdata: status[1:0], slot_index[8:2], bytes_used[19:9]
//   cfg_    | in  | data: fit_policy[1:0]
// Each operation takes 0 to 3 sweeps of the slot table, one slot per cycle,
// set by the scanner's single read port: one sweep for a free, up to three
// for a realloc that falls back.
// After reset a clearing pass over every slot runs before the first beat is taken.
// The result holds in out_tdata until taken; the next beat waits for that.
module fit_policy_block_allocator_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // action, owner_tag, request_size
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // status, slot_index, bytes_used
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_data    // fit_policy
);
  import fpba_pkg::*;

  policy_t  pol_r;
  dp_cmd_t  cmd;
  dp_stat_t stat;
  len_t     used;
  status_t  st;
  idx_t     slot;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n)         pol_r <= POL_FIRST;
    else if (cfg_valid) pol_r <= policy_t'(cfg_data);
  end

  fpba_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_tvalid), .in_ready(in_tready),
    .action(action_t'(in_tdata[1:0])), .tag(in_tdata[9:2]), .size(in_tdata[20:10]),
    .policy(pol_r), .cmd(cmd), .stat(stat),
    .res_valid(out_tvalid), .res_ready(out_tready),
    .res_status(st), .res_slot(slot)
  );

  fpba_datapath u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat), .used_total(used)
  );

  assign out_tdata = {4'd0, used, slot, st};
endmodule

/* design/fpba_datapath.sv */
// Slot table memories, sequential scanner and byte counter.
module fpba_datapath (
  input  logic              clk,
  input  logic              rst_n,
  input  fpba_pkg::dp_cmd_t cmd,
  output fpba_pkg::dp_stat_t stat,
  output fpba_pkg::len_t    used_total
);
  import fpba_pkg::*;

  len_t len_mem [SlotCount];
  tag_t own_mem [SlotCount];
  logic busy_mem [SlotCount];

  len_t used_r, used_nxt;
  logic clear_r;
  logic [IdxW:0] clr_cnt_r;

  // scanner
  logic          scan_r;
  scan_t         mode_r;
  policy_t       pol_r;
  logic [IdxW:0] cnt_r;
  logic          found_r;
  idx_t          hit_r;
  len_t          hitlen_r;
  logic          done_r;

  // registered read of current scan slot
  logic rv_r;
  idx_t ri_r;
  len_t rl_r;
  logic rb_r;
  tag_t ro_r;

  // registered random read
  len_t al_r;
  logic ab_r;

  logic match;
  logic take;

  always_comb begin
    match = 1'b0;
    take  = 1'b0;
    unique case (mode_r)
      SCAN_FIT: begin
        match = !rb_r && (rl_r >= cmd.req_len);
        unique case (pol_r)
          POL_FIRST: take = match && !found_r;
          POL_BEST:  take = match && (!found_r || rl_r < hitlen_r);
          POL_WORST: take = match && (rl_r > (found_r ? hitlen_r : '0));
          default:   take = 1'b0;
        endcase
      end
      SCAN_OWNER: begin
        match = rb_r && (ro_r == cmd.wr_tag);
        take  = match && !found_r;
      end
      SCAN_EMPTY: begin
        match = !rb_r && (rl_r == '0) && (ri_r > cmd.addr);
        take  = match && !found_r;
      end
      default: take = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_r  <= 1'b0;
      rv_r    <= 1'b0;
      done_r  <= 1'b0;
      found_r <= 1'b0;
      clear_r <= 1'b0;
      clr_cnt_r <= '0;
      mode_r  <= SCAN_FIT;
      pol_r   <= POL_FIRST;
      cnt_r   <= '0;
    end else begin
      done_r <= 1'b0;
      if (cmd.clear) begin
        clear_r   <= 1'b1;
        clr_cnt_r <= '0;
      end else if (clear_r) begin
        if (clr_cnt_r == (IdxW+1)'(SlotCount - 1)) clear_r <= 1'b0;
        clr_cnt_r <= clr_cnt_r + (IdxW+1)'(1);
      end
      if (cmd.scan_start) begin
        scan_r  <= 1'b1;
        mode_r  <= cmd.scan_mode;
        pol_r   <= cmd.policy;
        cnt_r   <= '0;
        found_r <= 1'b0;
        rv_r    <= 1'b0;
      end else begin
        rv_r <= scan_r && cnt_r < (IdxW+1)'(SlotCount);
        if (scan_r && cnt_r < (IdxW+1)'(SlotCount)) cnt_r <= cnt_r + (IdxW+1)'(1);
        if (rv_r && take) begin
          found_r  <= 1'b1;
          hit_r    <= ri_r;
          hitlen_r <= rl_r;
        end
        if (scan_r && cnt_r == (IdxW+1)'(SlotCount) && !rv_r) begin
          scan_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // memory read ports
  always_ff @(posedge clk) begin
    ri_r <= cnt_r[IdxW-1:0];
    rl_r <= len_mem[cnt_r[IdxW-1:0]];
    rb_r <= busy_mem[cnt_r[IdxW-1:0]];
    ro_r <= own_mem[cnt_r[IdxW-1:0]];
    al_r <= len_mem[cmd.addr];
    ab_r <= busy_mem[cmd.addr];
  end

  // memory write port
  always_ff @(posedge clk) begin
    if (clear_r) begin
      len_mem[clr_cnt_r[IdxW-1:0]]  <= (clr_cnt_r == '0) ? LenW'(MemoryBytes) : '0;
      busy_mem[clr_cnt_r[IdxW-1:0]] <= 1'b0;
      own_mem[clr_cnt_r[IdxW-1:0]]  <= '0;
    end else begin
      unique case (cmd.wr_op)
        WR_PLACE, WR_GROW: begin
          len_mem[cmd.addr]  <= cmd.wr_len;
          busy_mem[cmd.addr] <= 1'b1;
          own_mem[cmd.addr]  <= cmd.wr_tag;
        end
        WR_SPILL: begin
          len_mem[cmd.addr] <= cmd.wr_len;
          own_mem[cmd.addr] <= '0;
        end
        WR_RELEASE: begin
          busy_mem[cmd.addr] <= 1'b0;
          own_mem[cmd.addr]  <= '0;
        end
        WR_SHRINK, WR_TAKE: len_mem[cmd.addr] <= cmd.wr_len;
        default: ;
      endcase
    end
  end

  always_comb begin
    used_nxt = used_r;
    unique case (cmd.wr_op)
      WR_PLACE:   used_nxt = used_r + cmd.wr_len;
      WR_RELEASE: used_nxt = used_r - al_r;
      WR_SHRINK:  used_nxt = used_r - (al_r - cmd.wr_len);
      WR_GROW:    used_nxt = used_r + (cmd.wr_len - al_r);
      default:    used_nxt = used_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) used_r <= '0;
    else        used_r <= used_nxt;
  end

  assign used_total      = used_r;
  assign stat.scan_done  = done_r;
  assign stat.found      = found_r;
  assign stat.hit_idx    = hit_r;
  assign stat.hit_len    = hitlen_r;
  assign stat.rd_busy    = ab_r;
  assign stat.rd_len     = al_r;
  assign stat.clear_done = !clear_r && !cmd.clear;
endmodule

/* design/fpba_ctrl.sv */
// Sequencer for allocate, reallocate and free operations.
module fpba_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  fpba_pkg::action_t  action,
  input  fpba_pkg::len_t     size,
  input  fpba_pkg::tag_t     tag,
  input  fpba_pkg::policy_t  policy,
  output fpba_pkg::dp_cmd_t  cmd,
  input  fpba_pkg::dp_stat_t stat,
  output logic               res_valid,
  input  logic               res_ready,
  output fpba_pkg::status_t  res_status,
  output fpba_pkg::idx_t     res_slot
);
  import fpba_pkg::*;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_FIT, S_PLACE, S_EMPTY, S_PLACE2, S_OWNER, S_RD, S_RD2,
    S_NEXT_RD, S_NEXT_RD2, S_TAKE, S_GROW, S_DECIDE, S_SETTLE, S_OUT
  } state_t;

  state_t    state_r;
  action_t   act_r;
  len_t      size_r;
  tag_t      tag_r;
  idx_t      k_r;
  len_t      klen_r;
  len_t      rem_r;
  logic      place_r;  // after spill, write the placed block
  status_t   st_r;
  idx_t      slot_r;
  logic      start_r;
  scan_t     mode_r;
  policy_t   pol_r;
  wr_op_t    op_r;
  idx_t      addr_r;
  len_t      wlen_r;
  logic      clr_r;
  len_t      extra;

  assign extra = size_r - klen_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r   <= 1'b1;
      start_r <= 1'b0;
      op_r    <= WR_NONE;
      place_r <= 1'b0;
      mode_r  <= SCAN_FIT;
      pol_r   <= POL_FIRST;
      addr_r  <= '0;
    end else begin
      clr_r   <= 1'b0;
      start_r <= 1'b0;
      op_r    <= WR_NONE;
      unique case (state_r)
        S_CLEAR: if (!clr_r && stat.clear_done) state_r <= S_IDLE;
        S_IDLE: if (in_valid) begin
          act_r  <= action;
          size_r <= size;
          tag_r  <= tag;
          st_r   <= ST_NO_FIT;
          slot_r <= '0;
          addr_r <= '0;
          unique case (action)
            ACT_ALLOC: if (policy != POL_OFF) begin
              start_r <= 1'b1; mode_r <= SCAN_FIT; pol_r <= policy;
              state_r <= S_FIT;
            end else state_r <= S_OUT;
            ACT_REALLOC, ACT_FREE: begin
              start_r <= 1'b1; mode_r <= SCAN_OWNER; state_r <= S_OWNER;
            end
            default: state_r <= S_OUT;
          endcase
        end
        S_FIT: if (stat.scan_done && !start_r) begin
          if (stat.found) begin
            k_r    <= stat.hit_idx;
            klen_r <= stat.hit_len;
            addr_r <= stat.hit_idx;
            state_r <= S_PLACE;
          end else state_r <= S_OUT;
        end
        S_PLACE: begin
          if (klen_r > size_r) begin
            place_r <= 1'b1;
            rem_r   <= klen_r - size_r;
            start_r <= 1'b1; mode_r <= SCAN_EMPTY;
            state_r <= S_EMPTY;
          end else begin
            place_r <= 1'b0;
            op_r <= WR_PLACE; wlen_r <= size_r;
            st_r <= ST_OK; slot_r <= k_r;
            state_r <= S_SETTLE;
          end
        end
        S_EMPTY: if (stat.scan_done && !start_r) begin
          if (stat.found) begin
            addr_r <= stat.hit_idx; op_r <= WR_SPILL; wlen_r <= rem_r;
          end
          st_r <= ST_OK; slot_r <= k_r;
          state_r <= place_r ? S_PLACE2 : S_SETTLE;
        end
        // spill lands this cycle; write the placed block next
        S_PLACE2: begin
          addr_r <= k_r; op_r <= WR_PLACE; wlen_r <= size_r;
          place_r <= 1'b0;
          state_r <= S_SETTLE;
        end
        S_OWNER: if (stat.scan_done && !start_r) begin
          if (!stat.found) begin
            st_r <= ST_NO_OWNER; state_r <= S_OUT;
          end else begin
            k_r    <= stat.hit_idx;
            klen_r <= stat.hit_len;
            addr_r <= stat.hit_idx;
            state_r <= S_RD;
          end
        end
        S_RD: state_r <= S_RD2;
        S_RD2: begin
          if (act_r == ACT_FREE) begin
            op_r <= WR_RELEASE; st_r <= ST_OK; slot_r <= k_r; state_r <= S_SETTLE;
          end else if (size_r == klen_r) begin
            st_r <= ST_OK; slot_r <= k_r; state_r <= S_OUT;
          end else if (size_r < klen_r) begin
            op_r <= WR_SHRINK; wlen_r <= size_r;
            rem_r <= klen_r - size_r;
            place_r <= 1'b0;
            st_r <= ST_OK; slot_r <= k_r;
            start_r <= 1'b1; mode_r <= SCAN_EMPTY;
            state_r <= S_EMPTY;
          end else if (k_r != idx_t'(SlotCount - 1)) begin
            addr_r <= k_r + idx_t'(1); state_r <= S_NEXT_RD;
          end else begin
            state_r <= S_DECIDE;
          end
        end
        S_NEXT_RD: state_r <= S_NEXT_RD2;
        S_NEXT_RD2: begin
          if (!stat.rd_busy && stat.rd_len >= extra) begin
            op_r <= WR_TAKE; wlen_r <= stat.rd_len - extra;
            state_r <= S_TAKE;
          end else begin
            addr_r <= k_r; state_r <= S_DECIDE;
          end
        end
        // point the read port back at the grown slot before the grow write
        S_TAKE: begin
          addr_r <= k_r; state_r <= S_GROW;
        end
        S_GROW: begin
          op_r <= WR_GROW; wlen_r <= size_r;
          st_r <= ST_OK; slot_r <= k_r; state_r <= S_SETTLE;
        end
        S_DECIDE: begin
          op_r <= WR_RELEASE;
          start_r <= 1'b1; mode_r <= SCAN_FIT; pol_r <= POL_BEST;
          state_r <= S_FIT;
        end
        // let the last write update the byte count before the beat shows
        S_SETTLE: state_r <= S_OUT;
        S_OUT: if (res_ready) state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ready   = (state_r == S_IDLE);
  assign res_valid  = (state_r == S_OUT);
  assign res_status = st_r;
  assign res_slot   = (st_r == ST_OK) ? slot_r : '0;

  always_comb begin
    cmd.clear      = clr_r;
    cmd.scan_start = start_r;
    cmd.scan_mode  = mode_r;
    cmd.policy     = pol_r;
    cmd.req_len    = size_r;
    cmd.addr       = addr_r;
    cmd.wr_op      = op_r;
    cmd.wr_len     = wlen_r;
    cmd.wr_tag     = tag_r;
  end
endmodule

/* design/fpba_checker.sv */
// Port-level checks for the allocator, bound to the top level.
module fpba_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata
);
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid)) else $error("ready while result pending");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result dropped");
  a_fail_slot: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[1:0] != 2'd0 |-> out_tdata[8:2] == 7'd0)
    else $error("slot on failure");
  a_pad: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[23:20] == 4'd0) else $error("pad bits");
endmodule

bind fit_policy_block_allocator_top fpba_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
);

/* tb/fit_policy_block_allocator_top_tb.sv */
// Self-checking testbench for the fit-policy block allocator top level.
`timescale 1ns / 1ps
module fit_policy_block_allocator_top_tb;
  import fpba_pkg::*;

  typedef struct packed {
    status_t   status;
    logic [6:0] slot;
    logic [10:0] used;
  } alloc_res_t;

  // Table model: lengths, busy marks, owner tags and total bytes in use.
  class alloc_scoreboard;
    int unsigned blen[SlotCount];
    bit          bbusy[SlotCount];
    logic [7:0]  bown[SlotCount];
    int unsigned used_bytes;
    logic [1:0]  policy;
    alloc_res_t  pending[$];
    int          mismatches;
    int          results_seen;

    function new();
      foreach (blen[i]) begin
        blen[i] = 0; bbusy[i] = 0; bown[i] = 0;
      end
      blen[0] = MemoryBytes;
      used_bytes = 0;
      policy = POL_FIRST;
      mismatches = 0;
      results_seen = 0;
    endfunction

    function void spill(int from, int unsigned rem);
      for (int j = from + 1; j < SlotCount; j++) begin
        if (!bbusy[j] && blen[j] == 0) begin
          blen[j] = rem; bown[j] = 0;
          return;
        end
      end
    endfunction

    function void place(int k, int unsigned sz, logic [7:0] tag);
      if (blen[k] > sz) spill(k, blen[k] - sz);
      blen[k] = sz; bbusy[k] = 1; bown[k] = tag;
      used_bytes += sz;
    endfunction

    function int pick_fit(logic [1:0] pol, int unsigned sz);
      int pick;
      pick = -1;
      for (int i = 0; i < SlotCount; i++) begin
        if (bbusy[i] || blen[i] < sz) continue;
        if (pol == POL_FIRST) return i;
        if (pol == POL_BEST) begin
          if (pick < 0 || blen[i] < blen[pick]) pick = i;
        end else if (blen[i] > (pick < 0 ? 0 : blen[pick])) begin
          pick = i;
        end
      end
      return pick;
    endfunction

    function int owner_slot(logic [7:0] tag);
      for (int i = 0; i < SlotCount; i++)
        if (bbusy[i] && bown[i] == tag) return i;
      return -1;
    endfunction

    function void note_request(logic [1:0] act, logic [7:0] tag, int unsigned sz);
      status_t st;
      int slot, i;
      int unsigned rem, extra;
      alloc_res_t r;
      st = ST_NO_FIT;
      slot = -1;
      case (act)
        ACT_ALLOC: begin
          if (policy != POL_OFF) begin
            slot = pick_fit(policy, sz);
            if (slot >= 0) begin
              place(slot, sz, tag); st = ST_OK;
            end
          end
        end
        ACT_REALLOC: begin
          i = owner_slot(tag);
          if (i < 0) begin
            st = ST_NO_OWNER;
          end else if (sz == blen[i]) begin
            slot = i; st = ST_OK;
          end else if (sz < blen[i]) begin
            rem = blen[i] - sz;
            blen[i] = sz;
            spill(i, rem);
            used_bytes -= rem;
            slot = i; st = ST_OK;
          end else begin
            extra = sz - blen[i];
            if (i + 1 < SlotCount && !bbusy[i+1] && blen[i+1] >= extra) begin
              blen[i] = sz; blen[i+1] -= extra; used_bytes += extra;
              slot = i; st = ST_OK;
            end else begin
              used_bytes -= blen[i]; bbusy[i] = 0; bown[i] = 0;
              slot = pick_fit(POL_BEST, sz);
              if (slot >= 0) begin
                place(slot, sz, tag); st = ST_OK;
              end
            end
          end
        end
        ACT_FREE: begin
          i = owner_slot(tag);
          if (i < 0) begin
            st = ST_NO_OWNER;
          end else begin
            used_bytes -= blen[i]; bbusy[i] = 0; bown[i] = 0;
            slot = i; st = ST_OK;
          end
        end
        default: ;
      endcase
      r.status = st;
      r.slot = (st == ST_OK && slot >= 0) ? slot[6:0] : 7'd0;
      r.used = used_bytes[10:0];
      pending.push_back(r);
    endfunction

    function void check_result(logic [23:0] d);
      alloc_res_t got, exp_r;
      got.status = status_t'(d[1:0]);
      got.slot = d[8:2];
      got.used = d[19:9];
      results_seen++;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %h", d);
        return;
      end
      exp_r = pending.pop_front();
      if (got !== exp_r || d[23:20] !== 4'd0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: exp st=%0d slot=%0d used=%0d got st=%0d slot=%0d used=%0d",
                   exp_r.status, exp_r.slot, exp_r.used, got.status, got.slot, got.used);
      end
    endfunction
  endclass

  logic clk = 0, rst_n = 0;
  logic in_tvalid = 0, out_tready = 0, cfg_valid = 0;
  logic [23:0] in_tdata = 0;
  logic [1:0] cfg_data = 0;
  logic in_tready, out_tvalid, cfg_ready;
  logic [23:0] out_tdata;

  fit_policy_block_allocator_top uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  alloc_scoreboard sb = new();
  int send_idle_pct = 36, recv_idle_pct = 51;
  bit recv_hold = 0;
  int idle_cycles = 0;
  int items_sent = 0;
  localparam int IdleLimit = 20000;

  // Receiver: random back-pressure, or a long hold when requested.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
    out_tready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
  end

  // Watchdog on cycles with no accepted beat.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IdleLimit) begin
      $display("watchdog expired");
      $display("== FAIL ==");
      $finish;
    end
  end

  // Valid stays up after a beat until the next beat or an idle cycle replaces it.
  task automatic send_req(logic [1:0] act, logic [7:0] tag, logic [10:0] sz);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 0;
      @(posedge clk);
    end
    in_tvalid <= 1;
    in_tdata <= {3'd0, sz, tag, act};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_request(act, tag, sz);
    items_sent++;
  endtask

  task automatic drain();
    in_tvalid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (600) @(posedge clk);
  endtask

  task automatic write_policy(logic [1:0] pol);
    drain();
    cfg_valid <= 1;
    cfg_data <= pol;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.policy = pol;
    cfg_valid <= 0;
  endtask

  // Mostly small sizes, a few large; tags from a small pool so free/realloc hit.
  task automatic random_req();
    logic [1:0] act;
    logic [10:0] sz;
    int r;
    r = $urandom_range(99);
    act = (r < 40) ? ACT_ALLOC : (r < 65) ? ACT_REALLOC : (r < 95) ? ACT_FREE : ACT_NONE;
    r = $urandom_range(99);
    sz = (r < 80) ? 11'($urandom_range(64)) :
         (r < 95) ? 11'($urandom_range(400)) : 11'($urandom_range(2047));
    send_req(act, (($urandom_range(99) < 90) ? 8'($urandom_range(15)) :
                                               8'($urandom_range(255))), sz);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1;
    // Directed part.
    send_req(ACT_ALLOC, 8'd1, 11'd0);
    send_req(ACT_ALLOC, 8'd2, 11'd100);
    send_req(ACT_ALLOC, 8'd3, 11'd2047);
    send_req(ACT_ALLOC, 8'd255, 11'd50);
    send_req(ACT_REALLOC, 8'd2, 11'd100);
    send_req(ACT_REALLOC, 8'd2, 11'd40);
    send_req(ACT_REALLOC, 8'd2, 11'd70);
    send_req(ACT_REALLOC, 8'd255, 11'd500);
    send_req(ACT_REALLOC, 8'd77, 11'd10);
    send_req(ACT_FREE, 8'd1, 11'h7ff);
    send_req(ACT_FREE, 8'd1, 11'd0);
    send_req(ACT_NONE, 8'd9, 11'd9);
    write_policy(POL_BEST);
    send_req(ACT_ALLOC, 8'd4, 11'd30);
    send_req(ACT_REALLOC, 8'd4, 11'd2000);
    write_policy(POL_WORST);
    send_req(ACT_ALLOC, 8'd5, 11'd20);
    send_req(ACT_ALLOC, 8'd6, 11'd1024);
    write_policy(POL_OFF);
    send_req(ACT_ALLOC, 8'd7, 11'd5);
    send_req(ACT_FREE, 8'd255, 11'd0);
    write_policy(POL_FIRST);
    // Random phases with changing idle mix and policy.
    for (int ph = 0; ph < 6; ph++) begin
      if (ph == 2) begin send_idle_pct = 51; recv_idle_pct = 36; end
      if (ph == 4) begin send_idle_pct = 0; recv_idle_pct = 0; end
      write_policy(2'(ph % 3));
      for (int n = 0; n < 130; n++) random_req();
      if (ph == 3) begin
        // Hold the receiver off while requests keep coming.
        fork
          begin
            recv_hold = 1;
            repeat (3000) @(posedge clk);
            recv_hold = 0;
          end
          for (int n = 0; n < 5; n++) random_req();
        join
      end
    end
    drain();
    $display("ran %0d requests, %0d results checked over all fit policies",
             items_sent, sb.results_seen);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches, %0d left", sb.mismatches, sb.pending.size());
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
